[rtl/lru_buffer_pool_manager_unit_macros.svh]
// assertion macros for the buffer pool manager
`ifndef LRU_BUFFER_POOL_MANAGER_UNIT_MACROS_SVH
`define LRU_BUFFER_POOL_MANAGER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define LBPM_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbpm assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define LBPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbpm assertion failed");

`endif

[rtl/lbpm_pkg.sv]
// shared constants, codes and word types of the buffer pool manager
package lbpm_pkg;

  localparam int FRAME_COUNT    = 16;
  localparam int PAGE_ID_BITS   = 16;
  localparam int PIN_COUNT_BITS = 8;

  localparam int IDX_W      = $clog2(FRAME_COUNT);
  localparam int CNT_W      = $clog2(FRAME_COUNT + 1);
  localparam int CFG_W      = 5;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 4;

  localparam logic [CFG_W-1:0]          CFG_RESET = CFG_W'(16);
  localparam logic [PIN_COUNT_BITS-1:0] PIN_MAX   = '1;

  // request codes
  localparam logic [OPCODE_W-1:0] OP_PIN       = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_UNPIN     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FLUSH     = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_FLUSH_ALL = 2'd3;

  // result codes
  localparam logic [STATUS_W-1:0] ST_HIT        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_FILLED     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACED   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 4'd3;
  localparam logic [STATUS_W-1:0] ST_UNPINNED   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_RES    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_PIN_ZERO   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_FLUSHED    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_PIN_LIMIT  = 4'd8;

  typedef struct packed {
    logic [OPCODE_W-1:0]     opcode;
    logic [PAGE_ID_BITS-1:0] page_id;
    logic                    mark_dirty;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [IDX_W-1:0]          frame_index;
    logic                      fetch_valid;
    logic                      writeback_valid;
    logic [PAGE_ID_BITS-1:0]   writeback_page;
    logic [PIN_COUNT_BITS-1:0] pin_count_now;
    logic                      last_result;
  } out_word_t;

  // one entry of the frame table as seen at the read port
  typedef struct packed {
    logic                      valid;
    logic [PAGE_ID_BITS-1:0]   tag;
    logic [PIN_COUNT_BITS-1:0] pin;
    logic                      dirty;
    logic [IDX_W-1:0]          rank;
  } fs_rd_t;

  // single write port with per-field enables
  typedef struct packed {
    logic                      we;
    logic [IDX_W-1:0]          addr;
    logic                      set_valid;
    logic                      wr_tag;
    logic                      wr_pin;
    logic                      wr_dirty;
    logic                      wr_rank;
    logic [PAGE_ID_BITS-1:0]   tag;
    logic [PIN_COUNT_BITS-1:0] pin;
    logic                      dirty;
    logic [IDX_W-1:0]          rank;
  } fs_wr_t;

endpackage

[rtl/lru_buffer_pool_manager_unit.sv]
// top level of the buffer pool manager: request sequencer, output register, checks
//
// usage
// - requests come in as words on in_valid_i / in_stall_o / in_word_i and are taken
//   at a clock edge with valid high and stall low; results leave on
//   out_valid_o / out_stall_i / out_word_o the same way, one word per result
// - frames_in_use is written through cfg_we_i / cfg_wdata_i while the block is idle;
//   0 behaves as 1 and values above the frame count behave as the frame count
// - one frame-compare unit walks the frame table one entry per cycle; with n
//   frames in use (the register value after clamping) a request walks:
//     pin hit or eviction : the n-frame lookup walk, then a walk over all
//                           frames to close the recency gap
//     other requests      : the n-frame lookup walk only
//     flush-all           : the lookup walk, then a flush walk when some frame is dirty
// - the result sits in an output register; a new request is taken once the
//   sequencer is idle again, even while that result still waits to be taken
// - a stall on the output adds cycles: a full result register holds the commit
//   step, and a flush-all walk pauses on a dirty frame, until the word can be loaded
// - reset empties every frame, clears pin counts, dirty marks and ranks, sets
//   frames_in_use to 16 and drops any pending result
`include "lru_buffer_pool_manager_unit_macros.svh"

module lru_buffer_pool_manager_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lbpm_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lbpm_pkg::in_word_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lbpm_pkg::out_word_t         out_word_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_RANK   = 6'b001000,
    S_COMMIT = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [lbpm_pkg::CFG_W-1:0] cfg_q;
  logic [lbpm_pkg::CNT_W-1:0] n_clamp;

  // request held for the whole sequence
  logic [lbpm_pkg::OPCODE_W-1:0]     op_q;
  logic [lbpm_pkg::PAGE_ID_BITS-1:0] page_q;
  logic                              mdirty_q;
  logic [lbpm_pkg::CNT_W-1:0]        n_q;

  // walk pointer and what the lookup walk found
  logic [lbpm_pkg::IDX_W-1:0]          ptr_q;
  logic                                hit_q;
  logic [lbpm_pkg::IDX_W-1:0]          hit_idx_q;
  logic [lbpm_pkg::PIN_COUNT_BITS-1:0] hit_pin_q;
  logic                                hit_dirty_q;
  logic [lbpm_pkg::PAGE_ID_BITS-1:0]   hit_tag_q;
  logic [lbpm_pkg::IDX_W-1:0]          hit_rank_q;
  logic                                emp_q;
  logic [lbpm_pkg::IDX_W-1:0]          emp_idx_q;
  logic                                vic_q;
  logic [lbpm_pkg::IDX_W-1:0]          vic_idx_q;
  logic [lbpm_pkg::IDX_W-1:0]          vic_rank_q;
  logic                                vic_dirty_q;
  logic [lbpm_pkg::PAGE_ID_BITS-1:0]   vic_tag_q;
  logic [lbpm_pkg::CNT_W-1:0]          dcnt_q;
  logic [lbpm_pkg::CNT_W-1:0]          k_q;

  // frame being updated and its rank before the update
  logic [lbpm_pkg::IDX_W-1:0] tgt_q;
  logic [lbpm_pkg::IDX_W-1:0] trank_q;

  // number of valid frames over the whole table
  logic [lbpm_pkg::CNT_W-1:0] vcnt_q;

  // output register
  logic                 out_valid_q;
  lbpm_pkg::out_word_t  out_q;

  lbpm_pkg::fs_rd_t     rd;
  lbpm_pkg::fs_wr_t     wr;
  lbpm_pkg::out_word_t  emit_word;
  logic                 emit;
  logic                 can_emit;
  logic                 accept;
  logic                 ptr_at_end;
  logic                 rank_at_end;
  logic                 fill_go;
  logic                 flush_adv;
  logic                 flush_ent;
  logic                 flush_last;
  logic [lbpm_pkg::PIN_COUNT_BITS-1:0] pin_inc;
  logic [lbpm_pkg::IDX_W-1:0]          newest_rank;

  lbpm_frame_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (ptr_q),
    .rd_o      (rd),
    .wr_i      (wr)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign can_emit    = !out_valid_q || !out_stall_i;

  assign ptr_at_end  = ((lbpm_pkg::CNT_W'(ptr_q) + lbpm_pkg::CNT_W'(1)) == n_q);
  assign rank_at_end = (ptr_q == lbpm_pkg::IDX_W'(lbpm_pkg::FRAME_COUNT - 1));

  // saturating pin raise and the rank a frame gets when made most recent
  assign pin_inc     = (hit_pin_q == lbpm_pkg::PIN_MAX) ? hit_pin_q
                                                        : hit_pin_q + 1'b1;
  assign newest_rank = lbpm_pkg::IDX_W'(vcnt_q - lbpm_pkg::CNT_W'(1));

  // flush-all walk: a dirty valid frame in range produces a word
  assign flush_ent  = rd.valid && rd.dirty;
  assign flush_last = ((k_q + lbpm_pkg::CNT_W'(1)) == dcnt_q);

  // register value clamped into 1 .. FRAME_COUNT
  always_comb begin
    if (cfg_q == '0) begin
      n_clamp = lbpm_pkg::CNT_W'(1);
    end else if (int'(cfg_q) > lbpm_pkg::FRAME_COUNT) begin
      n_clamp = lbpm_pkg::CNT_W'(lbpm_pkg::FRAME_COUNT);
    end else begin
      n_clamp = lbpm_pkg::CNT_W'(cfg_q);
    end
  end

  // sequencer: next state, table write, result word
  always_comb begin
    state_d   = state_q;
    wr        = '0;
    wr.addr   = ptr_q;
    emit      = 1'b0;
    emit_word = '0;
    emit_word.last_result = 1'b1;
    fill_go   = 1'b0;
    flush_adv = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SCAN;
      end

      S_SCAN: begin
        if (ptr_at_end) state_d = S_DECIDE;
      end

      S_DECIDE: begin
        case (op_q)
          lbpm_pkg::OP_PIN: begin
            if (hit_q || (!emp_q && vic_q)) state_d = S_RANK;
            else                            state_d = S_COMMIT;
          end
          lbpm_pkg::OP_FLUSH_ALL: begin
            if (dcnt_q == '0) state_d = S_COMMIT;
            else              state_d = S_FLUSH;
          end
          default: state_d = S_COMMIT;
        endcase
      end

      // close the gap left by the target's old rank
      S_RANK: begin
        if (rd.valid && (ptr_q != tgt_q) && (rd.rank > trank_q)) begin
          wr.we      = 1'b1;
          wr.wr_rank = 1'b1;
          wr.rank    = rd.rank - 1'b1;
        end
        if (rank_at_end) state_d = S_COMMIT;
      end

      S_COMMIT: begin
        wr.addr = tgt_q;
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          case (op_q)
            lbpm_pkg::OP_PIN: begin
              if (hit_q) begin
                wr.we      = 1'b1;
                wr.wr_pin  = 1'b1;
                wr.pin     = pin_inc;
                wr.wr_rank = 1'b1;
                wr.rank    = newest_rank;
                emit_word.status = (hit_pin_q == lbpm_pkg::PIN_MAX)
                                   ? lbpm_pkg::ST_PIN_LIMIT : lbpm_pkg::ST_HIT;
                emit_word.frame_index   = hit_idx_q;
                emit_word.pin_count_now = pin_inc;
              end else if (emp_q) begin
                fill_go      = 1'b1;
                wr.we        = 1'b1;
                wr.set_valid = 1'b1;
                wr.wr_tag    = 1'b1;
                wr.tag       = page_q;
                wr.wr_pin    = 1'b1;
                wr.pin       = lbpm_pkg::PIN_COUNT_BITS'(1);
                wr.wr_dirty  = 1'b1;
                wr.dirty     = 1'b0;
                wr.wr_rank   = 1'b1;
                wr.rank      = lbpm_pkg::IDX_W'(vcnt_q);
                emit_word.status        = lbpm_pkg::ST_FILLED;
                emit_word.frame_index   = emp_idx_q;
                emit_word.fetch_valid   = 1'b1;
                emit_word.pin_count_now = lbpm_pkg::PIN_COUNT_BITS'(1);
              end else if (vic_q) begin
                wr.we       = 1'b1;
                wr.wr_tag   = 1'b1;
                wr.tag      = page_q;
                wr.wr_pin   = 1'b1;
                wr.pin      = lbpm_pkg::PIN_COUNT_BITS'(1);
                wr.wr_dirty = 1'b1;
                wr.dirty    = 1'b0;
                wr.wr_rank  = 1'b1;
                wr.rank     = newest_rank;
                emit_word.status          = lbpm_pkg::ST_REPLACED;
                emit_word.frame_index     = vic_idx_q;
                emit_word.fetch_valid     = 1'b1;
                emit_word.writeback_valid = vic_dirty_q;
                emit_word.writeback_page  = vic_dirty_q ? vic_tag_q : '0;
                emit_word.pin_count_now   = lbpm_pkg::PIN_COUNT_BITS'(1);
              end else begin
                emit_word.status = lbpm_pkg::ST_ALL_PINNED;
              end
            end

            lbpm_pkg::OP_UNPIN: begin
              if (!hit_q) begin
                emit_word.status = lbpm_pkg::ST_NOT_RES;
              end else if (hit_pin_q == '0) begin
                emit_word.status      = lbpm_pkg::ST_PIN_ZERO;
                emit_word.frame_index = hit_idx_q;
              end else begin
                wr.we       = 1'b1;
                wr.wr_pin   = 1'b1;
                wr.pin      = hit_pin_q - 1'b1;
                wr.wr_dirty = 1'b1;
                wr.dirty    = hit_dirty_q || mdirty_q;
                emit_word.status        = lbpm_pkg::ST_UNPINNED;
                emit_word.frame_index   = hit_idx_q;
                emit_word.pin_count_now = hit_pin_q - 1'b1;
              end
            end

            lbpm_pkg::OP_FLUSH: begin
              if (!hit_q) begin
                emit_word.status = lbpm_pkg::ST_NOT_RES;
              end else begin
                wr.we       = 1'b1;
                wr.wr_dirty = 1'b1;
                wr.dirty    = 1'b0;
                emit_word.status          = lbpm_pkg::ST_FLUSHED;
                emit_word.frame_index     = hit_idx_q;
                emit_word.writeback_valid = hit_dirty_q;
                emit_word.writeback_page  = hit_dirty_q ? hit_tag_q : '0;
                emit_word.pin_count_now   = hit_pin_q;
              end
            end

            // flush-all with nothing dirty
            default: begin
              emit_word.status = lbpm_pkg::ST_FLUSHED;
            end
          endcase
        end
      end

      // one frame per cycle, pausing on a dirty frame while the output is full
      S_FLUSH: begin
        if (flush_ent) begin
          if (can_emit) begin
            emit        = 1'b1;
            flush_adv   = 1'b1;
            wr.we       = 1'b1;
            wr.wr_dirty = 1'b1;
            wr.dirty    = 1'b0;
            emit_word.status          = lbpm_pkg::ST_FLUSHED;
            emit_word.frame_index     = ptr_q;
            emit_word.writeback_valid = 1'b1;
            emit_word.writeback_page  = rd.tag;
            emit_word.pin_count_now   = rd.pin;
            emit_word.last_result     = flush_last;
            if (flush_last) state_d = S_IDLE;
          end
        end else begin
          flush_adv = 1'b1;
          if (ptr_at_end) state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= lbpm_pkg::CFG_RESET;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (fill_go)  vcnt_q <= vcnt_q + 1'b1;
      if (emit)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (emit) out_q <= emit_word;
  end

  // walk registers and what the lookup found
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      hit_q  <= 1'b0;
      emp_q  <= 1'b0;
      vic_q  <= 1'b0;
      dcnt_q <= '0;
      k_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ptr_q  <= '0;
            hit_q  <= 1'b0;
            emp_q  <= 1'b0;
            vic_q  <= 1'b0;
            dcnt_q <= '0;
          end
        end

        S_SCAN: begin
          // lowest index wins on a duplicate tag
          if (rd.valid && (rd.tag == page_q) && !hit_q) hit_q <= 1'b1;
          if (!rd.valid && !emp_q) emp_q <= 1'b1;
          if ((rd.pin == '0) && (!vic_q || (rd.rank < vic_rank_q))) vic_q <= 1'b1;
          if (rd.valid && rd.dirty) dcnt_q <= dcnt_q + 1'b1;
          if (!ptr_at_end) ptr_q <= ptr_q + 1'b1;
        end

        S_DECIDE: begin
          ptr_q <= '0;
          k_q   <= '0;
        end

        S_RANK: begin
          if (!rank_at_end) ptr_q <= ptr_q + 1'b1;
        end

        S_FLUSH: begin
          if (flush_adv && !ptr_at_end) ptr_q <= ptr_q + 1'b1;
          if (emit) k_q <= k_q + 1'b1;
        end

        default: ;
      endcase
    end
  end

  // payload captured along the walk
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q     <= in_word_i.opcode;
          page_q   <= in_word_i.page_id;
          mdirty_q <= in_word_i.mark_dirty;
          n_q      <= n_clamp;
        end
      end

      S_SCAN: begin
        if (rd.valid && (rd.tag == page_q) && !hit_q) begin
          hit_idx_q   <= ptr_q;
          hit_pin_q   <= rd.pin;
          hit_dirty_q <= rd.dirty;
          hit_tag_q   <= rd.tag;
          hit_rank_q  <= rd.rank;
        end
        if (!rd.valid && !emp_q) emp_idx_q <= ptr_q;
        if ((rd.pin == '0) && (!vic_q || (rd.rank < vic_rank_q))) begin
          vic_idx_q   <= ptr_q;
          vic_rank_q  <= rd.rank;
          vic_dirty_q <= rd.dirty;
          vic_tag_q   <= rd.tag;
        end
      end

      S_DECIDE: begin
        if (op_q == lbpm_pkg::OP_PIN && !hit_q && emp_q) begin
          tgt_q   <= emp_idx_q;
          trank_q <= '0;
        end else if (op_q == lbpm_pkg::OP_PIN && !hit_q) begin
          tgt_q   <= vic_idx_q;
          trank_q <= vic_rank_q;
        end else begin
          tgt_q   <= hit_idx_q;
          trank_q <= hit_rank_q;
        end
      end

      default: ;
    endcase
  end

  // checks
  `LBPM_ASSERT(a_vcnt_bound, 1'b1, vcnt_q <= lbpm_pkg::CNT_W'(lbpm_pkg::FRAME_COUNT))
  `LBPM_ASSERT_NEXT(a_accept_starts_walk, accept, state_q == S_SCAN)
  `LBPM_ASSERT(a_fill_has_room, fill_go, vcnt_q < lbpm_pkg::CNT_W'(lbpm_pkg::FRAME_COUNT))
  `LBPM_ASSERT(a_emit_never_overwrites, emit, !out_valid_q || !out_stall_i)

endmodule

[rtl/lbpm_frame_store.sv]
// frame table: valid, tag, pin count, dirty and recency rank per frame
module lbpm_frame_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lbpm_pkg::IDX_W-1:0]      rd_addr_i,
  output lbpm_pkg::fs_rd_t                rd_o,
  input  lbpm_pkg::fs_wr_t                wr_i
);

  logic [lbpm_pkg::FRAME_COUNT-1:0]    valid_q;
  logic [lbpm_pkg::FRAME_COUNT-1:0]    dirty_q;
  logic [lbpm_pkg::PAGE_ID_BITS-1:0]   tag_q  [lbpm_pkg::FRAME_COUNT];
  logic [lbpm_pkg::PIN_COUNT_BITS-1:0] pin_q  [lbpm_pkg::FRAME_COUNT];
  logic [lbpm_pkg::IDX_W-1:0]          rank_q [lbpm_pkg::FRAME_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < lbpm_pkg::FRAME_COUNT; i++) begin
        pin_q[i]  <= '0;
        rank_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      if (wr_i.set_valid) valid_q[wr_i.addr] <= 1'b1;
      if (wr_i.wr_pin)    pin_q[wr_i.addr]   <= wr_i.pin;
      if (wr_i.wr_dirty)  dirty_q[wr_i.addr] <= wr_i.dirty;
      if (wr_i.wr_rank)   rank_q[wr_i.addr]  <= wr_i.rank;
    end
  end

  // tags only mean something once their frame is valid
  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_i.wr_tag) tag_q[wr_i.addr] <= wr_i.tag;
  end

  always_comb begin
    rd_o.valid = valid_q[rd_addr_i];
    rd_o.tag   = tag_q[rd_addr_i];
    rd_o.pin   = pin_q[rd_addr_i];
    rd_o.dirty = dirty_q[rd_addr_i];
    rd_o.rank  = rank_q[rd_addr_i];
  end

endmodule
